>>> rtl/wmsd_pkg.sv
// Shared types and constants of the window mean settling detector.
package wmsd_pkg;

  localparam int TIME_W    = 32;
  localparam int VALUE_W   = 24;
  localparam int TOL_W     = 24;
  localparam int QUO_W     = 24;
  localparam int PROD_W    = TIME_W + 1 + VALUE_W;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETTLE_ENABLE = 2'd0,
    CFG_TOLERANCE     = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0]         sample_time;
    logic signed [VALUE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic                      settled;
    logic                      settled_now;
    logic                      window_full;
    logic [TIME_W-1:0]         latest_time;
    logic signed [VALUE_W-1:0] latest_value;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]         stamp;
    logic signed [VALUE_W-1:0] value;
  } hist_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic recent;
    logic last;
  } ent_ctl_t;

endpackage

>>> rtl/wmsd_hist.sv
// Sample history memory with one write port and one registered read port.
module wmsd_hist import wmsd_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  hist_t         wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output hist_t         rd_data_o
);

  hist_t mem_q [DEPTH];
  hist_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/wmsd_accum.sv
// Time-weighted sum and time span accumulation over the history walk.
module wmsd_accum import wmsd_pkg::*; #(
  parameter int SUM_W  = 62,
  parameter int SPAN_W = 37
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ent_ctl_t                ent_i,
  input  hist_t                   ent_data_i,
  output logic signed [SUM_W-1:0] sum_long_o,
  output logic signed [SUM_W-1:0] sum_recent_o,
  output logic [SPAN_W-1:0]       span_long_o,
  output logic [SPAN_W-1:0]       span_recent_o,
  output logic                    done_o
);

  logic [TIME_W-1:0]         prev_q;
  logic [TIME_W-1:0]         dt;
  logic signed [TIME_W:0]    dt_s;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic signed [SUM_W-1:0]   prod_ext;
  logic [TIME_W-1:0]         dt_q;
  logic                      acc_q, clr_q, recent_q, last_q, done_q;
  logic signed [SUM_W-1:0]   sum_long_q, sum_recent_q;
  logic [SPAN_W-1:0]         span_long_q, span_recent_q;

  assign dt       = ent_data_i.stamp - prev_q;
  assign dt_s     = $signed({1'b0, dt});
  assign prod_d   = dt_s * ent_data_i.value;
  assign prod_ext = SUM_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (ent_i.valid) begin
      prev_q <= ent_data_i.stamp;
    end
    prod_q   <= prod_d;
    dt_q     <= dt;
    recent_q <= ent_i.recent;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= 1'b0;
      clr_q  <= 1'b0;
      last_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      acc_q  <= ent_i.valid && !ent_i.first;
      clr_q  <= ent_i.valid && ent_i.first;
      last_q <= ent_i.valid && ent_i.last;
      done_q <= acc_q && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      sum_long_q    <= '0;
      sum_recent_q  <= '0;
      span_long_q   <= '0;
      span_recent_q <= '0;
    end else if (acc_q) begin
      sum_long_q  <= sum_long_q + prod_ext;
      span_long_q <= span_long_q + SPAN_W'(dt_q);
      if (recent_q) begin
        sum_recent_q  <= sum_recent_q + prod_ext;
        span_recent_q <= span_recent_q + SPAN_W'(dt_q);
      end
    end
  end

  assign sum_long_o    = sum_long_q;
  assign sum_recent_o  = sum_recent_q;
  assign span_long_o   = span_long_q;
  assign span_recent_o = span_recent_q;
  assign done_o        = done_q;

endmodule

>>> rtl/wmsd_div.sv
// Bit-serial restoring divider producing one quotient bit per cycle.
module wmsd_div import wmsd_pkg::*; #(
  parameter int NUM_W = 62,
  parameter int DEN_W = 37
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             done_o
);

  localparam int SH_W  = DEN_W + QUO_W - 1;
  localparam int CMP_W = (NUM_W > SH_W) ? NUM_W : SH_W;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [NUM_W-1:0] rem_q;
  logic [SH_W-1:0]  dsh_q;
  logic [QUO_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q;
  logic             ge;
  logic [CMP_W-1:0] diff;

  assign ge   = CMP_W'(rem_q) >= CMP_W'(dsh_q);
  assign diff = CMP_W'(rem_q) - CMP_W'(dsh_q);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= {den_i, {(QUO_W-1){1'b0}}};
      quo_q <= '0;
    end else if (run_q) begin
      if (ge) begin
        rem_q <= diff[NUM_W-1:0];
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(QUO_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

>>> rtl/window_mean_settling_detector.sv
// Window mean settling detector top level: control, registers and decision.
// With no check running, an accepted sample goes straight to the output stage;
// when a check runs, it first walks the history at one read per cycle, then
// drains the accumulate pipeline and, unless a time span is zero, runs the serial division.
// Throughput: one transaction in flight; the next is taken once the result is queued.
// Reset clears control, fill count, registers and the settled flag; the history
// memory is not cleared.
module window_mean_settling_detector import wmsd_pkg::*; #(
  parameter int HALF_WINDOW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TOL_W-1:0]     cfg_data_i
);

  localparam int W      = 2 * HALF_WINDOW;
  localparam int AW     = $clog2(W);
  localparam int CNT_W  = $clog2(W + 1);
  localparam int SUM_W  = PROD_W + $clog2(W);
  localparam int SPAN_W = TIME_W + $clog2(W);
  localparam int DIF_W  = QUO_W + 2;

  state_e state_q, state_d;

  logic              enable_q;
  logic [TOL_W-1:0]  tol_q;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic              full_q, full_d;
  logic              settled_q, settled_d;
  logic              now_q, now_d;
  in_item_t          item_q;
  logic              out_valid_q;
  out_item_t         out_q;
  ent_ctl_t          ent_q, ent_d;
  logic              neg_l_q, neg_s_q;

  logic              in_fire;
  logic              rd_en;
  logic              div_start;
  logic              load_out;
  logic              full_next;
  hist_t             wr_data, rd_data;

  logic signed [SUM_W-1:0] sum_long, sum_recent;
  logic [SPAN_W-1:0]       span_long, span_recent;
  logic                    acc_done;
  logic [SUM_W-1:0]        mag_long, mag_recent;
  logic [QUO_W-1:0]        quo_long, quo_recent;
  logic                    div_l_done, div_s_done;

  logic signed [QUO_W:0]   mean_l, mean_s;
  logic signed [DIF_W-1:0] diff;
  logic [DIF_W-1:0]        abs_diff;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign full_next   = full_q || (fill_q == CNT_W'(W - 1));

  assign wr_data.stamp = in_data_i.sample_time;
  assign wr_data.value = in_data_i.sample_value;

  wmsd_hist #(
    .DEPTH (W),
    .AW    (AW)
  ) u_hist (
    .clk_i     (clk_i),
    .wr_en_i   (in_fire),
    .wr_addr_i (ptr_q),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr_q),
    .rd_data_o (rd_data)
  );

  wmsd_accum #(
    .SUM_W  (SUM_W),
    .SPAN_W (SPAN_W)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ent_i         (ent_q),
    .ent_data_i    (rd_data),
    .sum_long_o    (sum_long),
    .sum_recent_o  (sum_recent),
    .span_long_o   (span_long),
    .span_recent_o (span_recent),
    .done_o        (acc_done)
  );

  assign mag_long   = sum_long[SUM_W-1] ? SUM_W'(-sum_long) : SUM_W'(sum_long);
  assign mag_recent = sum_recent[SUM_W-1] ? SUM_W'(-sum_recent) : SUM_W'(sum_recent);

  wmsd_div #(
    .NUM_W (SUM_W),
    .DEN_W (SPAN_W)
  ) u_div_long (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mag_long),
    .den_i   (span_long),
    .quo_o   (quo_long),
    .done_o  (div_l_done)
  );

  wmsd_div #(
    .NUM_W (SUM_W),
    .DEN_W (SPAN_W)
  ) u_div_recent (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mag_recent),
    .den_i   (span_recent),
    .quo_o   (quo_recent),
    .done_o  (div_s_done)
  );

  assign mean_l   = neg_l_q ? -$signed({1'b0, quo_long}) : $signed({1'b0, quo_long});
  assign mean_s   = neg_s_q ? -$signed({1'b0, quo_recent}) : $signed({1'b0, quo_recent});
  assign diff     = mean_l - mean_s;
  assign abs_diff = diff[DIF_W-1] ? DIF_W'(-diff) : DIF_W'(diff);

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    ptr_d     = ptr_q;
    addr_d    = addr_q;
    idx_d     = idx_q;
    full_d    = full_q;
    settled_d = settled_q;
    now_d     = now_q;
    ent_d     = '0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ptr_d  = (ptr_q == AW'(W - 1)) ? '0 : ptr_q + 1'b1;
          fill_d = full_q ? fill_q : fill_q + 1'b1;
          full_d = full_next;
          now_d  = 1'b0;
          addr_d = ptr_d;
          idx_d  = '0;
          if (enable_q && !settled_q && full_next) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_WALK: begin
        rd_en        = 1'b1;
        ent_d.valid  = 1'b1;
        ent_d.first  = (idx_q == '0);
        ent_d.recent = (idx_q >= AW'(HALF_WINDOW));
        ent_d.last   = (idx_q == AW'(W - 1));
        addr_d       = (addr_q == AW'(W - 1)) ? '0 : addr_q + 1'b1;
        idx_d        = idx_q + 1'b1;
        if (idx_q == AW'(W - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (acc_done) begin
          if ((span_long == '0) || (span_recent == '0)) begin
            state_d = ST_OUT;
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_l_done && div_s_done) begin
          if (abs_diff < DIF_W'(tol_q)) begin
            settled_d = 1'b1;
            now_d     = 1'b1;
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      ptr_q       <= '0;
      addr_q      <= '0;
      idx_q       <= '0;
      full_q      <= 1'b0;
      settled_q   <= 1'b0;
      now_q       <= 1'b0;
      ent_q       <= '0;
      out_valid_q <= 1'b0;
      enable_q    <= 1'b0;
      tol_q       <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      ptr_q     <= ptr_d;
      addr_q    <= addr_d;
      idx_q     <= idx_d;
      full_q    <= full_d;
      settled_q <= settled_d;
      now_q     <= now_d;
      ent_q     <= ent_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_SETTLE_ENABLE: enable_q <= cfg_data_i[0];
          CFG_TOLERANCE:     tol_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (div_start) begin
      neg_l_q <= sum_long[SUM_W-1];
      neg_s_q <= sum_recent[SUM_W-1];
    end
    if (load_out) begin
      out_q.settled      <= settled_q;
      out_q.settled_now  <= now_q;
      out_q.window_full  <= full_q;
      out_q.latest_time  <= item_q.sample_time;
      out_q.latest_value <= item_q.sample_value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_settled_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settled_q |=> settled_q)
    else $error("settled flag cleared");

  a_acc_done_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_done |-> (state_q == ST_DRAIN))
    else $error("accumulator finished outside drain");

  a_div_done_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_l_done || div_s_done) |-> (state_q == ST_DIV) && div_l_done && div_s_done)
    else $error("dividers out of step");

  a_now_implies_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.settled_now) |-> out_data_o.settled)
    else $error("settled_now without settled");

endmodule
